@@ rtl/sewr_pkg.sv @@
// ----------------------------------------------------------------------------
// sewr_pkg
// Shared opcodes, error codes, field widths and the command type that passes
// from the front end to the execution engine.
// ----------------------------------------------------------------------------
package sewr_pkg;

    localparam int OP_W    = 3;
    localparam int CNT_W   = 7;
    localparam int STEP_W  = 8;
    localparam int SIZE_W  = 7;
    localparam int ERR_W   = 2;

    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP    = 3'd1;
    localparam logic [OP_W-1:0] OP_DROP   = 3'd2;
    localparam logic [OP_W-1:0] OP_TRIM   = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK   = 3'd4;
    localparam logic [OP_W-1:0] OP_GET    = 3'd5;
    localparam logic [OP_W-1:0] OP_ROTATE = 3'd6;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_OVFL  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_UNDER = 2'd2;
    localparam logic [ERR_W-1:0] ERR_SPAN  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [CNT_W-1:0]         n;
        logic                     n_zero;
        logic signed [STEP_W-1:0] step;
        logic                     rev;
    } t_cmd;

endpackage

@@ rtl/sewr_front.sv @@
// ----------------------------------------------------------------------------
// sewr_front
// Accepts input transactions, decodes them into commands and holds them in a
// two-entry queue for the execution engine.
// ----------------------------------------------------------------------------
module sewr_front #(
    parameter int ITEM_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [sewr_pkg::OP_W-1:0]   i_opcode,
    input  logic [ITEM_WIDTH-1:0] i_value,
    input  logic [sewr_pkg::CNT_W-1:0]  i_count,
    input  logic [sewr_pkg::STEP_W-1:0] i_step,
    input  logic                  i_rev,
    output logic                  o_cmd_valid,
    input  logic                  i_cmd_pop,
    output sewr_pkg::t_cmd        o_cmd,
    output logic [ITEM_WIDTH-1:0] o_value
);

    sewr_pkg::t_cmd        r_cmd [2];
    logic [ITEM_WIDTH-1:0] r_val [2];
    logic                  r_wp, r_rp;
    logic [1:0]            r_cnt;
    sewr_pkg::t_cmd        dec;
    logic                  push_en;

    always_comb begin
        dec.op     = i_opcode;
        dec.n      = i_count;
        dec.n_zero = (i_count == '0);
        dec.step   = i_step;
        dec.rev    = i_rev;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign push_en     = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_cmd[r_rp];
    assign o_value     = r_val[r_rp];

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_cmd[r_wp] <= dec;
            r_val[r_wp] <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_en) r_wp <= ~r_wp;
            if (i_cmd_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push_en} - {1'b0, i_cmd_pop};
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count out of range");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> r_cnt != 2'd0) else $error("pop from empty queue");
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 && !i_cmd_pop |=> r_cnt == 2'd2)
        else $error("queue lost an entry");

endmodule

@@ rtl/sewr_back.sv @@
// ----------------------------------------------------------------------------
// sewr_back
// Execution engine: item memory, size register, step reduction, get walk,
// rotate through a scratch memory, and the output register.
// ----------------------------------------------------------------------------
module sewr_back #(
    parameter int DEPTH      = 64,
    parameter int ITEM_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_pop,
    input  sewr_pkg::t_cmd        i_cmd,
    input  logic [ITEM_WIDTH-1:0] i_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [ITEM_WIDTH-1:0] o_item,
    output logic [sewr_pkg::SIZE_W-1:0] o_size,
    output logic                  o_last,
    output logic [sewr_pkg::ERR_W-1:0]  o_err
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = sewr_pkg::SIZE_W;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RESP = 4'd1;
    localparam logic [3:0] ST_GRD  = 4'd2;
    localparam logic [3:0] ST_GWT  = 4'd3;
    localparam logic [3:0] ST_MOD  = 4'd4;
    localparam logic [3:0] ST_RR   = 4'd5;
    localparam logic [3:0] ST_RW   = 4'd6;
    localparam logic [3:0] ST_SR   = 4'd7;
    localparam logic [3:0] ST_SW   = 4'd8;

    logic [ITEM_WIDTH-1:0] mem  [DEPTH];
    logic [ITEM_WIDTH-1:0] scr  [DEPTH];
    logic [ITEM_WIDTH-1:0] r_rdata, r_sdata;

    logic [3:0]          r_state, n_state;
    logic [SW-1:0]       r_size, n_size;
    logic [SW-1:0]       r_i, n_i, r_j, n_j, r_n, n_n;
    logic                r_rev, n_rev;
    logic [8:0]          r_rem, n_rem;
    logic                r_neg, n_neg;
    logic [sewr_pkg::ERR_W-1:0] r_res_err, n_res_err;

    logic                r_ovalid, n_ovalid;
    logic [ITEM_WIDTH-1:0] r_oitem, n_oitem;
    logic [SW-1:0]       r_osize, n_osize;
    logic                r_olast, n_olast;
    logic [sewr_pkg::ERR_W-1:0] r_oerr, n_oerr;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [ITEM_WIDTH-1:0] wr_data;
    logic                rd_en;
    logic [SW-1:0]       rd_idx;
    logic                sw_en, sr_en;
    logic                out_free;
    logic [SW-1:0]       start, gidx, span_idx;
    logic [8:0]          mag;

    assign out_free = !r_ovalid || i_ready;
    assign start    = r_size - r_n;
    assign span_idx = start + r_i;
    assign gidx     = r_rev ? (start + r_i) : (r_size - 7'd1 - r_i);
    assign mag      = i_cmd.step[7] ? (9'd0 - {i_cmd.step[7], i_cmd.step})
                                    : {1'b0, i_cmd.step};

    always_comb begin
        n_state   = r_state;
        n_size    = r_size;
        n_i       = r_i;
        n_j       = r_j;
        n_n       = r_n;
        n_rev     = r_rev;
        n_rem     = r_rem;
        n_neg     = r_neg;
        n_res_err = r_res_err;
        n_ovalid  = r_ovalid && !i_ready;
        n_oitem   = r_oitem;
        n_osize   = r_osize;
        n_olast   = r_olast;
        n_oerr    = r_oerr;
        o_cmd_pop = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = r_size[AW-1:0];
        wr_data   = i_value;
        rd_en     = 1'b0;
        rd_idx    = gidx;
        sw_en     = 1'b0;
        sr_en     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_res_err = sewr_pkg::ERR_OK;
                    n_state   = ST_RESP;
                    n_i       = '0;
                    n_n       = i_cmd.n;
                    n_rev     = i_cmd.rev;
                    case (i_cmd.op)
                        sewr_pkg::OP_PUSH: begin
                            if (r_size == SW'(DEPTH)) begin
                                n_res_err = sewr_pkg::ERR_OVFL;
                            end else begin
                                wr_en  = 1'b1;
                                n_size = r_size + 7'd1;
                            end
                        end
                        sewr_pkg::OP_POP, sewr_pkg::OP_DROP: begin
                            if (i_cmd.n > r_size) n_res_err = sewr_pkg::ERR_UNDER;
                            else n_size = r_size - i_cmd.n;
                        end
                        sewr_pkg::OP_TRIM: begin
                            if (i_cmd.n < r_size) n_size = i_cmd.n;
                        end
                        sewr_pkg::OP_PEEK: begin
                            if (r_size == '0) begin
                                n_res_err = sewr_pkg::ERR_UNDER;
                            end else begin
                                n_n     = 7'd1;
                                n_rev   = 1'b0;
                                n_state = ST_GRD;
                            end
                        end
                        sewr_pkg::OP_GET: begin
                            if (i_cmd.n > r_size) n_res_err = sewr_pkg::ERR_UNDER;
                            else if (!i_cmd.n_zero) n_state = ST_GRD;
                        end
                        sewr_pkg::OP_ROTATE: begin
                            if (i_cmd.n_zero) begin
                                n_res_err = sewr_pkg::ERR_SPAN;
                            end else if (i_cmd.n > r_size) begin
                                n_res_err = sewr_pkg::ERR_UNDER;
                            end else begin
                                n_rem   = mag;
                                n_neg   = i_cmd.step[7];
                                n_state = ST_MOD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oitem  = '0;
                    n_osize  = r_size;
                    n_olast  = 1'b1;
                    n_oerr   = r_res_err;
                    n_state  = ST_IDLE;
                end
            end
            ST_GRD: begin
                rd_en   = 1'b1;
                n_state = ST_GWT;
            end
            ST_GWT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oitem  = r_rdata;
                    n_osize  = r_size;
                    n_olast  = (r_i == r_n - 7'd1);
                    n_oerr   = sewr_pkg::ERR_OK;
                    n_i      = r_i + 7'd1;
                    n_state  = (r_i == r_n - 7'd1) ? ST_IDLE : ST_GRD;
                end
            end
            ST_MOD: begin
                if (r_rem >= {2'b00, r_n}) begin
                    n_rem = r_rem - {2'b00, r_n};
                end else begin
                    n_j     = (r_neg && r_rem != '0) ? (r_n - r_rem[SW-1:0])
                                                     : r_rem[SW-1:0];
                    n_i     = '0;
                    n_state = ST_RR;
                end
            end
            ST_RR: begin
                rd_en   = 1'b1;
                rd_idx  = span_idx;
                n_state = ST_RW;
            end
            ST_RW: begin
                sw_en   = 1'b1;
                n_j     = (r_j + 7'd1 == r_n) ? '0 : r_j + 7'd1;
                if (r_i == r_n - 7'd1) begin
                    n_i     = '0;
                    n_state = ST_SR;
                end else begin
                    n_i     = r_i + 7'd1;
                    n_state = ST_RR;
                end
            end
            ST_SR: begin
                sr_en   = 1'b1;
                n_state = ST_SW;
            end
            ST_SW: begin
                wr_en   = 1'b1;
                wr_addr = span_idx[AW-1:0];
                wr_data = r_sdata;
                if (r_i == r_n - 7'd1) begin
                    n_res_err = sewr_pkg::ERR_OK;
                    n_state   = ST_RESP;
                end else begin
                    n_i     = r_i + 7'd1;
                    n_state = ST_SR;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) r_rdata <= mem[rd_idx[AW-1:0]];
        if (sw_en) scr[r_j[AW-1:0]] <= r_rdata;
        if (sr_en) r_sdata <= scr[r_i[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_size   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_size   <= n_size;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_j       <= n_j;
        r_n       <= n_n;
        r_rev     <= n_rev;
        r_rem     <= n_rem;
        r_neg     <= n_neg;
        r_res_err <= n_res_err;
        r_oitem   <= n_oitem;
        r_osize   <= n_osize;
        r_olast   <= n_olast;
        r_oerr    <= n_oerr;
    end

    assign o_valid = r_ovalid;
    assign o_item  = r_oitem;
    assign o_size  = r_osize;
    assign o_last  = r_olast;
    assign o_err   = r_oerr;

    a_size_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_size <= SW'(DEPTH)) else $error("size beyond depth");
    a_get_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_GWT |-> r_i < r_n) else $error("get index past count");
    a_rot_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RW |-> r_j < r_n) else $error("rotate target past span");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> r_state == ST_IDLE) else $error("command taken while busy");

endmodule

@@ rtl/stack_engine_with_rotate_top.sv @@
// ----------------------------------------------------------------------------
// stack_engine_with_rotate_top
// LIFO stack of item words with push, pop, drop, trim, peek, get and rotate.
//
// Input stream carries one command per transaction; output stream returns
// one result per command, or count results for a successful get of
// nonzero count, with tlast on the final one. A two-entry command queue
// decouples intake from the execution engine, so intake keeps going while
// a result waits.
// Engine steps per command (memory has one registered read port):
//   push, pop, drop, trim, failed ops: decode, result
//   peek: decode, read, result;  get: decode, then read and result per item
//   rotate: decode, reduce step modulo span by repeated subtraction,
//   read and scratch write per item, write-back per item, result
// Reset empties the stack and the queue; memory contents are not cleared.
// A stalled receiver holds the output register and the engine waits; intake
// stops once the queue is full.
// ----------------------------------------------------------------------------
module stack_engine_with_rotate_top #(
    parameter int DEPTH      = 64,
    parameter int ITEM_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // opcode, value, count, step_amount, reverse_order
    input  logic [((ITEM_WIDTH+19+7)/8)*8-1:0] i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // item_out, size_out, error_code
    output logic [((ITEM_WIDTH+9+7)/8)*8-1:0]  o_m_axis_tdata,
    output logic              o_m_axis_tlast
);

    localparam int IW  = ITEM_WIDTH;
    localparam int OWD = ((IW+9+7)/8)*8;

    logic                  cmd_valid, cmd_pop;
    sewr_pkg::t_cmd        cmd;
    logic [IW-1:0]         cmd_value;
    logic [IW-1:0]         item;
    logic [6:0]            size;
    logic [1:0]            err;

    sewr_front #(.ITEM_WIDTH(IW)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_opcode    (i_s_axis_tdata[2:0]),
        .i_value     (i_s_axis_tdata[IW+2:3]),
        .i_count     (i_s_axis_tdata[IW+9:IW+3]),
        .i_step      (i_s_axis_tdata[IW+17:IW+10]),
        .i_rev       (i_s_axis_tdata[IW+18]),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd),
        .o_value     (cmd_value)
    );

    sewr_back #(.DEPTH(DEPTH), .ITEM_WIDTH(IW)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_cmd       (cmd),
        .i_value     (cmd_value),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_item      (item),
        .o_size      (size),
        .o_last      (o_m_axis_tlast),
        .o_err       (err)
    );

    assign o_m_axis_tdata = OWD'({err, size, item});

endmodule
